// ===== rtl/stld_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the scrolling two-line text display.
// Depends on nothing; stld_ctrl, stld_dp and the top level import it.
package stld_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_CHAR  = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_ROW   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  // Character codes.
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Commands from the controller to the datapath for one cycle.
  typedef struct packed {
    logic       issue;     // a result word enters the output pipe
    logic       from_mem;  // its value comes from the screen store read
    logic [1:0] kind;
    logic [7:0] imm;       // value when not read from the screen store
    logic       last;
    logic       line_wr;   // store a character into the line store
    logic       fill_rd;   // read one line cell for the bottom-row fill
    logic       fill_pad;  // that fill cell lies beyond the line and gets a space
    logic       clear;     // blank the whole screen
  } stld_cmd_t;

endpackage

// ===== rtl/stld_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the text display: valid/ready plus one input word.
// Depends on nothing.
interface stld_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] char_in;
  logic [4:0] cell_index;

  modport source (output valid, output opcode, output char_in, output cell_index,
                  input ready);
  modport sink (input valid, input opcode, input char_in, input cell_index,
                output ready);
endinterface

// ===== rtl/stld_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the text display: valid/ready plus one result word.
// Depends on nothing.
interface stld_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic       last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink (input valid, input kind, input value, input last, output ready);
endinterface

// ===== rtl/stld_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the text display: line store, screen store with valid bits,
// read stage and two-word output queue. Depends on stld_pkg and stld_out_if.
module stld_dp #(
  parameter int LINE_LENGTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  stld_pkg::stld_cmd_t               cmd,
  input  logic [$clog2(2*LINE_LENGTH)-1:0]  rd_addr,
  input  logic [$clog2(LINE_LENGTH)-1:0]    line_wr_addr,
  input  logic [6:0]                        line_wr_data,
  input  logic [$clog2(LINE_LENGTH)-1:0]    fill_line_addr,
  input  logic [$clog2(2*LINE_LENGTH)-1:0]  fill_scr_addr,
  output logic                              can_issue,
  stld_out_if.source                        out_ch
);
  import stld_pkg::*;

  localparam int SCREEN_CELLS = 2 * LINE_LENGTH;
  localparam int ADDR_W       = $clog2(SCREEN_CELLS);

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } item_t;

  // Stores.
  logic [6:0]              line_mem [LINE_LENGTH];
  logic [6:0]              scr_mem  [SCREEN_CELLS];
  logic [SCREEN_CELLS-1:0] scr_vld_r;

  // Bottom-row fill stage.
  logic              fill_wr_r;
  logic [ADDR_W-1:0] fill_addr_r;
  logic              fill_pad_r;
  logic [6:0]        line_q_r;
  logic [6:0]        fill_data;

  // Read stage.
  logic       s1_vld_r;
  logic       s1_from_mem_r;
  logic [1:0] s1_kind_r;
  logic [7:0] s1_imm_r;
  logic       s1_last_r;
  logic [6:0] mem_q_r;
  logic       vld_q_r;
  item_t      s1_item;

  // Output queue.
  item_t      fifo_q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       pop;
  logic [2:0] room_use;

  // Line store: character writes and fill reads.
  always_ff @(posedge clk) begin
    if (cmd.line_wr) begin
      line_mem[line_wr_addr] <= line_wr_data;
    end
    if (cmd.fill_rd) begin
      line_q_r <= line_mem[fill_line_addr];
    end
  end

  // Fill stage control is registered in step with the line store read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_wr_r <= 1'b0;
    end else begin
      fill_wr_r <= cmd.fill_rd;
    end
  end

  always_ff @(posedge clk) begin
    fill_addr_r <= fill_scr_addr;
    fill_pad_r  <= cmd.fill_pad;
  end

  assign fill_data = fill_pad_r ? CH_SPACE[6:0] : line_q_r;

  // Screen store: fill writes and result reads.
  always_ff @(posedge clk) begin
    if (fill_wr_r) begin
      scr_mem[fill_addr_r] <= fill_data;
    end
    if (cmd.issue && cmd.from_mem) begin
      mem_q_r <= scr_mem[rd_addr];
    end
  end

  // Valid bits: an entry never written since reset or clear reads as a space.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_vld_r <= '0;
      vld_q_r   <= 1'b0;
    end else begin
      if (cmd.clear) begin
        scr_vld_r <= '0;
      end else if (fill_wr_r) begin
        scr_vld_r[fill_addr_r] <= 1'b1;
      end
      if (cmd.issue && cmd.from_mem) begin
        vld_q_r <= scr_vld_r[rd_addr];
      end
    end
  end

  // Read stage holding the word in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_from_mem_r <= cmd.from_mem;
      s1_kind_r     <= cmd.kind;
      s1_imm_r      <= cmd.imm;
      s1_last_r     <= cmd.last;
    end
  end

  always_comb begin
    s1_item.kind  = s1_kind_r;
    s1_item.last  = s1_last_r;
    if (s1_from_mem_r) begin
      s1_item.value = vld_q_r ? {1'b0, mem_q_r} : CH_SPACE;
    end else begin
      s1_item.value = s1_imm_r;
    end
  end

  // Two-word output queue; room counts the word still in the read stage.
  assign pop      = out_ch.valid && out_ch.ready;
  assign room_use = {1'b0, cnt_r} - {2'b00, pop} + {2'b00, s1_vld_r};
  assign can_issue = room_use < 3'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (s1_vld_r) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= room_use[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      fifo_q_r[wr_ptr_r] <= s1_item;
    end
  end

  assign out_ch.valid = (cnt_r != 2'd0);
  assign out_ch.kind  = fifo_q_r[rd_ptr_r].kind;
  assign out_ch.value = fifo_q_r[rd_ptr_r].value;
  assign out_ch.last  = fifo_q_r[rd_ptr_r].last;

endmodule

// ===== rtl/stld_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the text display: decodes input words, keeps the line
// position and row order, and sequences the redraw. Depends on stld_pkg, stld_in_if.
module stld_ctrl #(
  parameter int LINE_LENGTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  stld_in_if.sink                           in_ch,
  input  logic                              can_issue,
  output stld_pkg::stld_cmd_t               cmd,
  output logic [$clog2(2*LINE_LENGTH)-1:0]  rd_addr,
  output logic [$clog2(LINE_LENGTH)-1:0]    line_wr_addr,
  output logic [6:0]                        line_wr_data,
  output logic [$clog2(LINE_LENGTH)-1:0]    fill_line_addr,
  output logic [$clog2(2*LINE_LENGTH)-1:0]  fill_scr_addr
);
  import stld_pkg::*;

  localparam int SCREEN_CELLS = 2 * LINE_LENGTH;
  localparam int ADDR_W       = $clog2(SCREEN_CELLS);
  localparam int COL_W        = $clog2(LINE_LENGTH);
  localparam int POS_W        = $clog2(LINE_LENGTH + 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(LINE_LENGTH - 1);
  localparam logic [POS_W-1:0]  POS_FULL  = POS_W'(LINE_LENGTH);
  localparam logic [ADDR_W-1:0] ROW1_BASE = ADDR_W'(LINE_LENGTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TOP  = 2'd1;
  localparam logic [1:0] ST_ROW1 = 2'd2;
  localparam logic [1:0] ST_BOT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             top_sel_r, top_sel_nxt;
  logic [COL_W-1:0] emit_col_r, emit_col_nxt;
  logic             fill_act_r, fill_act_nxt;
  logic [COL_W-1:0] fill_col_r, fill_col_nxt;

  logic             accept;
  logic             printable;
  logic             cell_ok;
  logic             cell_bot;
  logic [COL_W-1:0] cell_col;

  // Physical screen address of a column in physical row prow.
  function automatic logic [ADDR_W-1:0] phys_addr(input logic prow,
                                                  input logic [COL_W-1:0] col);
    phys_addr = (prow ? ROW1_BASE : '0) + ADDR_W'(col);
  endfunction

  assign in_ch.ready = (state_r == ST_IDLE) && can_issue;
  assign accept      = in_ch.valid && in_ch.ready;

  // Input word decode.
  assign printable = (in_ch.char_in >= CH_SPACE) && (in_ch.char_in <= CH_TILDE);
  assign cell_ok   = int'(in_ch.cell_index) < SCREEN_CELLS;
  assign cell_bot  = int'(in_ch.cell_index) >= LINE_LENGTH;
  assign cell_col  = cell_bot ? COL_W'(int'(in_ch.cell_index) - LINE_LENGTH)
                              : COL_W'(in_ch.cell_index);

  // Next state and commands.
  always_comb begin
    cmd            = '0;
    rd_addr        = '0;
    line_wr_addr   = pos_r[COL_W-1:0];
    line_wr_data   = in_ch.char_in[6:0];
    fill_line_addr = fill_col_r;
    fill_scr_addr  = phys_addr(~top_sel_r, fill_col_r);
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    top_sel_nxt    = top_sel_r;
    emit_col_nxt   = emit_col_r;
    fill_act_nxt   = fill_act_r;
    fill_col_nxt   = fill_col_r;

    // The new bottom row is written one column a cycle, never stalled.
    if (fill_act_r) begin
      cmd.fill_rd  = 1'b1;
      cmd.fill_pad = POS_W'(fill_col_r) >= pos_r;
      if (fill_col_r == COL_LAST) begin
        fill_act_nxt = 1'b0;
        fill_col_nxt = '0;
      end else begin
        fill_col_nxt = fill_col_r + 1'b1;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_ch.opcode)
            OP_CHAR: begin
              priority if (in_ch.char_in == CH_NEWLINE) begin
                // Scroll by swapping row order, then redraw from row 0.
                cmd.issue    = 1'b1;
                cmd.kind     = KIND_ROW;
                cmd.imm      = 8'd0;
                top_sel_nxt  = ~top_sel_r;
                fill_act_nxt = 1'b1;
                fill_col_nxt = '0;
                emit_col_nxt = '0;
                state_nxt    = ST_TOP;
              end else if (printable && (pos_r < POS_FULL)) begin
                cmd.line_wr = 1'b1;
                pos_nxt     = pos_r + 1'b1;
              end else begin
                pos_nxt = pos_r;
              end
            end
            OP_CLEAR: begin
              cmd.issue = 1'b1;
              cmd.kind  = KIND_CLEAR;
              cmd.imm   = 8'd0;
              cmd.last  = 1'b1;
              cmd.clear = 1'b1;
              pos_nxt   = '0;
            end
            OP_READ: begin
              if (cell_ok) begin
                cmd.issue    = 1'b1;
                cmd.from_mem = 1'b1;
                cmd.kind     = KIND_READ;
                cmd.last     = 1'b1;
                rd_addr      = phys_addr(cell_bot ^ top_sel_r, cell_col);
              end
            end
            default: begin
              pos_nxt = pos_r;
            end
          endcase
        end
      end
      ST_TOP: begin
        rd_addr = phys_addr(top_sel_r, emit_col_r);
        if (can_issue) begin
          cmd.issue    = 1'b1;
          cmd.from_mem = 1'b1;
          cmd.kind     = KIND_DATA;
          if (emit_col_r == COL_LAST) begin
            emit_col_nxt = '0;
            state_nxt    = ST_ROW1;
          end else begin
            emit_col_nxt = emit_col_r + 1'b1;
          end
        end
      end
      ST_ROW1: begin
        if (can_issue) begin
          cmd.issue = 1'b1;
          cmd.kind  = KIND_ROW;
          cmd.imm   = 8'd1;
          state_nxt = ST_BOT;
        end
      end
      ST_BOT: begin
        rd_addr = phys_addr(~top_sel_r, emit_col_r);
        if (can_issue) begin
          cmd.issue    = 1'b1;
          cmd.from_mem = 1'b1;
          cmd.kind     = KIND_DATA;
          if (emit_col_r == COL_LAST) begin
            cmd.last     = 1'b1;
            emit_col_nxt = '0;
            pos_nxt      = '0;
            state_nxt    = ST_IDLE;
          end else begin
            emit_col_nxt = emit_col_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      pos_r      <= '0;
      top_sel_r  <= 1'b0;
      emit_col_r <= '0;
      fill_act_r <= 1'b0;
      fill_col_r <= '0;
    end else begin
      state_r    <= state_nxt;
      pos_r      <= pos_nxt;
      top_sel_r  <= top_sel_nxt;
      emit_col_r <= emit_col_nxt;
      fill_act_r <= fill_act_nxt;
      fill_col_r <= fill_col_nxt;
    end
  end

endmodule

// ===== rtl/scrolling_two_line_text_display.sv =====
`timescale 1ns / 1ps
// Top level of the scrolling two-line text display: controller, datapath and
// checks. Depends on stld_pkg, stld_in_if, stld_out_if, stld_ctrl and stld_dp.
//
// Usage: words arrive on in_ch (opcode, char_in, cell_index) and result words
// leave on out_ch (kind, value, last); both are valid/ready channels and a
// word moves at a clock edge with valid and ready high.
// A character, ignored or stored, gives no result.
// A clear or a cell read gives one result, which passes through the read
// stage and then the output queue before it is valid on out_ch.
// A newline gives 2*LINE_LENGTH+2 results (34 by default) issued one per
// cycle while the queue has room, since the single read port of the screen
// store delivers one cell a cycle; the next word is taken only after the
// last one is issued and the controller is back in idle.
// The new bottom row is written beside the top-row readout, and scrolling
// only swaps the order of the two physical rows.
// Results pass through a two-word queue, so a stalled receiver holds the
// sequence back without loss; in_ch.ready stays low while no room is left.
// Synchronous reset (rst_n low) blanks the screen through per-cell valid
// bits at once, rewinds the line position and empties the queue.
module scrolling_two_line_text_display #(
  parameter int LINE_LENGTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  stld_in_if.sink     in_ch,
  stld_out_if.source  out_ch
);
  import stld_pkg::*;

  localparam int ADDR_W = $clog2(2 * LINE_LENGTH);
  localparam int COL_W  = $clog2(LINE_LENGTH);

  stld_cmd_t         cmd;
  logic              can_issue;
  logic [ADDR_W-1:0] rd_addr;
  logic [COL_W-1:0]  line_wr_addr;
  logic [6:0]        line_wr_data;
  logic [COL_W-1:0]  fill_line_addr;
  logic [ADDR_W-1:0] fill_scr_addr;

  stld_ctrl #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .can_issue      (can_issue),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .line_wr_addr   (line_wr_addr),
    .line_wr_data   (line_wr_data),
    .fill_line_addr (fill_line_addr),
    .fill_scr_addr  (fill_scr_addr)
  );

  stld_dp #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .line_wr_addr   (line_wr_addr),
    .line_wr_data   (line_wr_data),
    .fill_line_addr (fill_line_addr),
    .fill_scr_addr  (fill_scr_addr),
    .can_issue      (can_issue),
    .out_ch         (out_ch)
  );

  // A word enters the output pipe only when the queue has room for it.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.issue |-> can_issue)
    else $error("result word issued without queue room");

  // No input word is taken while the bottom row is still being written.
  assert property (@(posedge clk) disable iff (!rst_n)
                   cmd.fill_rd |-> !(in_ch.valid && in_ch.ready))
    else $error("input word accepted during bottom-row fill");

  // Clearing the screen never overlaps a fill.
  assert property (@(posedge clk) disable iff (!rst_n) cmd.clear |-> !cmd.fill_rd)
    else $error("screen clear during bottom-row fill");

  // A set-row command never closes the results of an input word.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_ch.valid && (out_ch.kind == KIND_ROW)) |-> !out_ch.last)
    else $error("set-row result marked last");

endmodule
